### rtl/tcw_pkg.sv
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int OPCODE_W = 2;
	localparam int CHAR_W   = 8;
	localparam int ROW_IN_W = 5;
	localparam int COL_IN_W = 7;
	localparam int IDX_IN_W = 11;
	localparam int CURIDX_W = 11;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [OPCODE_W-1:0] OP_PUT    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SETCUR = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NOP    = 2'd3;

	localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h07;
	localparam logic [ATTR_W-1:0] ATTR_BLINK_MASK = 8'h7F;

	localparam logic [CFG_IDX_W-1:0] REG_ATTR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK = 1'b1;

	typedef struct packed {
		logic [CURIDX_W-1:0] cursor_index;
		logic [CELL_W-1:0]   cell_value;
		logic                scrolled;
	} res_t;

endpackage

### rtl/text_console_writer.sv
// out_valid is registered: it rises once the engine's finish state hands the result on
// a word that scrolls adds one pass over the cell memory: rows copied up, last row blanked
// a new word is taken only once the last is through; in_ready low while a word is at work
// the cell memory has one write and one read port, which sets the scroll length
// reset: cursor home, attribute 7, blink off; then a clearing pass over all
// ROWS*COLUMNS cells (2000 by default) zeroes the cells with in_ready low
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [ROW_IN_W-1:0]   row_in,
	input  logic [COL_IN_W-1:0]   col_in,
	input  logic [IDX_IN_W-1:0]   cell_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CURIDX_W-1:0]   cursor_index,
	output logic [CELL_W-1:0]     cell_value,
	output logic                  scrolled
);

	logic [ATTR_W-1:0] attr_q;
	logic              blink_q;
	logic [ATTR_W-1:0] attr_live;
	logic              out_valid_q;
	res_t              res_q;
	res_t              res;
	logic              res_valid;
	logic              res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= ATTR_RESET;
			blink_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTR:  attr_q  <= cfg_data;
				REG_BLINK: blink_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign attr_live = blink_q ? attr_q : (attr_q & ATTR_BLINK_MASK);

	tcw_engine #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.char_code (char_code),
		.row_in    (row_in),
		.col_in    (col_in),
		.cell_index(cell_index),
		.attr      (attr_live),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// output word register holds one result; the engine waits while it is full and the sink stalls
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign cursor_index = res_q.cursor_index;
	assign cell_value   = res_q.cell_value;
	assign scrolled     = res_q.scrolled;

endmodule

### rtl/tcw_cell_ram.sv
module tcw_cell_ram import tcw_pkg::*; #(
	parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/tcw_engine.sv
module tcw_engine import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [ROW_IN_W-1:0] row_in,
	input  logic [COL_IN_W-1:0] col_in,
	input  logic [IDX_IN_W-1:0] cell_index,
	input  logic [ATTR_W-1:0]   attr,
	input  logic                res_free,
	output logic                res_valid,
	output res_t                res
);

	localparam int CELLS   = ROWS * COLUMNS;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int RCMP_W  = (ROW_W > ROW_IN_W) ? ROW_W : ROW_IN_W;
	localparam int CCMP_W  = (COL_W > COL_IN_W) ? COL_W : COL_IN_W;
	localparam int ICMP_W  = (CELL_AW > IDX_IN_W) ? CELL_AW : IDX_IN_W;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_FINISH = 3'd2;
	localparam logic [2:0] S_COPY   = 3'd3;
	localparam logic [2:0] S_FILL   = 3'd4;

	logic [2:0]         state_q;
	logic [CELL_AW-1:0] ptr_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               scr_q;
	logic               rd_q;
	logic               rd_ok_q;
	logic               cp_vld_s1;
	logic [CELL_AW-1:0] cp_addr_s1;

	logic               accept;
	logic               is_cr, is_lf, last_row, last_col;
	logic               put_scroll, put_write;
	logic               ptr_last;
	logic [CELL_AW-1:0] ptr_inc;
	logic [CELL_AW-1:0] cur_lin;

	logic               ram_we, ram_re;
	logic [CELL_AW-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0]  ram_wdata, ram_rdata;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign is_cr    = (char_code == CODE_CR);
	assign is_lf    = (char_code == CODE_LF);
	assign last_row = (row_q == ROW_W'(ROWS - 1));
	assign last_col = (col_q == COL_W'(COLUMNS - 1));
	assign put_scroll = is_lf ? last_row : (!is_cr && last_col && last_row);
	assign put_write  = accept && (opcode == OP_PUT) && !is_cr && !is_lf;

	assign cur_lin = CELL_AW'(row_q) * CELL_AW'(COLUMNS) + CELL_AW'(col_q);

	// shared sweep counter: clear pass, row copy and blank fill
	assign ptr_inc  = ptr_q + CELL_AW'(1);
	assign ptr_last = (state_q == S_COPY) ? (ptr_q == CELL_AW'(CELLS - COLUMNS - 1))
	                                      : (ptr_q == CELL_AW'(CELLS - 1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		if (cp_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_FILL) begin
			ram_we    = 1'b1;
			ram_wdata = {attr, CODE_SPACE};
		end else if (put_write) begin
			ram_we    = 1'b1;
			ram_waddr = cur_lin;
			ram_wdata = {attr, char_code};
		end
	end

	assign ram_re    = (state_q == S_COPY) || (accept && (opcode == OP_READ));
	assign ram_raddr = (state_q == S_COPY) ? ptr_q + CELL_AW'(COLUMNS)
	                                       : CELL_AW'(cell_index);

	tcw_cell_ram #(
		.DEPTH(CELLS),
		.AW   (CELL_AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ptr_q     <= '0;
			scr_q     <= 1'b0;
			rd_q      <= 1'b0;
			rd_ok_q   <= 1'b0;
			cp_vld_s1 <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == S_COPY);
			unique case (state_q)
				S_CLEAR: begin
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
				S_IDLE: begin
					if (accept) begin
						scr_q   <= (opcode == OP_PUT) && put_scroll;
						rd_q    <= (opcode == OP_READ);
						rd_ok_q <= ICMP_W'(cell_index) < ICMP_W'(CELLS);
						ptr_q   <= '0;
						if ((opcode == OP_PUT) && put_scroll) begin
							state_q <= S_COPY;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_COPY: begin
					if (ptr_last) begin
						ptr_q   <= CELL_AW'(CELLS - COLUMNS);
						state_q <= S_FILL;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
				S_FILL: begin
					// last copied word takes the write port first
					if (!cp_vld_s1) begin
						if (ptr_last) begin
							state_q <= S_FINISH;
						end else begin
							ptr_q <= ptr_inc;
						end
					end
				end
				S_FINISH: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			case (opcode)
				OP_PUT: begin
					if (put_scroll) begin
						row_q <= ROW_W'(ROWS - 1);
						col_q <= '0;
					end else if (is_cr) begin
						col_q <= '0;
					end else if (is_lf) begin
						row_q <= row_q + ROW_W'(1);
					end else if (last_col) begin
						row_q <= row_q + ROW_W'(1);
						col_q <= '0;
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				OP_SETCUR: begin
					if (RCMP_W'(row_in) > RCMP_W'(ROWS - 1)) begin
						row_q <= ROW_W'(ROWS - 1);
					end else begin
						row_q <= ROW_W'(row_in);
					end
					if (CCMP_W'(col_in) > CCMP_W'(COLUMNS - 1)) begin
						col_q <= COL_W'(COLUMNS - 1);
					end else begin
						col_q <= COL_W'(col_in);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res_valid          = (state_q == S_FINISH) && res_free;
	assign res.cursor_index   = CURIDX_W'(cur_lin);
	assign res.cell_value     = (rd_q && rd_ok_q) ? ram_rdata : '0;
	assign res.scrolled       = scr_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= ROW_W'(ROWS - 1)) && (col_q <= COL_W'(COLUMNS - 1)))
		else $error("cursor out of range");

	a_copy_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> $past(state_q) == S_COPY)
		else $error("copy write without a copy read");

	a_fill_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> ptr_q >= CELL_AW'(CELLS - COLUMNS))
		else $error("blank fill outside last row");

	a_result_after_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && scr_q) |-> (row_q == ROW_W'(ROWS - 1)) && (col_q == '0))
		else $error("scroll left cursor off last row start");

endmodule
